### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable, fixed message
`define SDT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sdt assertion failed");

// same with a caller message
`define SDT_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

### src/sdt_pkg.sv
// package: command and status codes, chain carry type
package sdt_pkg;

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_ALLOC  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISS      = 3'd1;
  localparam logic [2:0] ST_IN_USE    = 3'd2;
  localparam logic [2:0] ST_ABSENT    = 3'd3;
  localparam logic [2:0] ST_EXHAUSTED = 3'd4;

  localparam logic [16:0] RPORT_ANY = 17'h1FFFF;
  localparam logic [6:0]  COUNT_MAX = 7'd127;

  typedef struct packed {
    logic        live;
    logic        hit;
    logic [1:0]  level;
    logic        own_valid;
    logic [15:0] own_lp;
    logic        ev;
    logic [15:0] ev_lp;
  } sdt_carry_t;

endpackage

### src/sdt_in_if.sv
// interfaces for the command and result channels
interface sdt_in_if #(parameter int ADDR_BITS = 32);
  logic                 valid;
  logic                 ready;
  logic [2:0]           command;
  logic [ADDR_BITS-1:0] local_addr;
  logic [ADDR_BITS-1:0] remote_addr;
  logic [15:0]          local_port;
  logic signed [16:0]   remote_port;
  logic [5:0]           conn_id;
  modport source (output valid, command, local_addr, remote_addr, local_port,
                  remote_port, conn_id, input ready);
  modport sink (input valid, command, local_addr, remote_addr, local_port,
                remote_port, conn_id, output ready);
endinterface

interface sdt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  found_conn;
  logic [1:0]  match_level;
  logic [15:0] port;
  modport source (output valid, status, found_conn, match_level, port, input ready);
  modport sink (input valid, status, found_conn, match_level, port, output ready);
endinterface

### src/sdt_cell.sv
// one connection entry of the chain: key storage, compare, carry stage
module sdt_cell #(
  parameter int IDX       = 0,
  parameter int IW        = 6,
  parameter int ADDR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_pass,
  input  logic [2:0]           q_cmd,
  input  logic [ADDR_BITS-1:0] q_la,
  input  logic [ADDR_BITS-1:0] q_ra,
  input  logic [15:0]          q_lp,
  input  logic [16:0]          q_rp,
  input  logic [5:0]           q_id,
  input  logic [15:0]          q_keep,
  input  sdt_pkg::sdt_carry_t  c_in,
  input  logic [IW-1:0]        id_in,
  output sdt_pkg::sdt_carry_t  c_out,
  output logic [IW-1:0]        id_out
);
  import sdt_pkg::*;

  logic                 valid_r, valid_nxt;
  logic [ADDR_BITS-1:0] la_r, ra_r;
  logic [15:0]          lp_r;
  logic [16:0]          rp_r;
  sdt_carry_t           c_r, c_nxt;
  logic [IW-1:0]        id_r, id_nxt;
  logic [3:0]           m;
  logic [1:0]           lvl;
  logic                 own, lp_eq, la0, ra0, evict, wr_all, wr_addr;

  always_comb begin
    own   = (32'(q_id) == 32'(IDX));
    lp_eq = (lp_r == q_lp);
    la0   = (la_r == '0);
    ra0   = (ra_r == '0);
    m[0] = valid_r && la_r == q_la && ra_r == q_ra && lp_eq && rp_r == q_rp;
    m[1] = valid_r && la0 && ra_r == q_ra && lp_eq && rp_r == q_rp;
    m[2] = valid_r && la_r == q_la && ra0 && lp_eq && rp_r == RPORT_ANY;
    m[3] = valid_r && la0 && ra0 && lp_eq && rp_r == RPORT_ANY;
    lvl = m[0] ? 2'd0 : m[1] ? 2'd1 : m[2] ? 2'd2 : 2'd3;
    evict = c_in.live && q_pass && q_cmd == CMD_UPDATE && !own && valid_r &&
            la_r == q_la && ra_r == q_ra && lp_r == q_keep && rp_r == q_rp;
    wr_all  = c_in.live && q_pass && own && q_cmd == CMD_INSERT;
    wr_addr = c_in.live && q_pass && own && (q_cmd == CMD_INSERT || q_cmd == CMD_UPDATE);
    c_nxt     = c_in;
    id_nxt    = id_in;
    valid_nxt = valid_r;
    if (c_in.live && !q_pass) begin
      if (|m && (!c_in.hit || lvl < c_in.level)) begin
        c_nxt.hit   = 1'b1;
        c_nxt.level = lvl;
        id_nxt      = IW'(IDX);
      end
      if (own) begin
        c_nxt.own_valid = valid_r;
        c_nxt.own_lp    = lp_r;
      end
    end
    if (evict) begin
      valid_nxt   = 1'b0;
      c_nxt.ev    = 1'b1;
      c_nxt.ev_lp = lp_r;
    end
    if (wr_all) valid_nxt = 1'b1;
    if (c_in.live && q_pass && own && q_cmd == CMD_REMOVE) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      c_r     <= '0;
    end else begin
      valid_r <= valid_nxt;
      c_r     <= c_nxt;
    end
    id_r <= id_nxt;
    if (wr_addr) begin
      la_r <= q_la;
      ra_r <= q_ra;
      rp_r <= q_rp;
    end
    if (wr_all) lp_r <= q_lp;
  end

  assign c_out  = c_r;
  assign id_out = id_r;
endmodule

### src/sdt_port_mem.sv
// port use count memory, one write and one registered read port
module sdt_port_mem #(
  parameter int DEPTH = 3976,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);
  logic [6:0] mem [DEPTH];
  logic [6:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### src/socket_pair_demux_table_core.sv
// top level: connection table chain, port counters and command sequencer
// a lookup takes one pass down the chain; insert, update and remove take a search
//   pass and, if it goes ahead, a write pass, then count updates as read and write back
// allocate: probes ports in the use count memory, each as a read then a check
// one command at a time; the next beat is taken once the result is registered
// reset: table emptied at once, then a clearing sweep of the use count memory
//   (PORT_LIMIT-PORT_FIRST entries, 3976 by default) before the first beat
module socket_pair_demux_table_core #(
  parameter int CONN_ENTRIES = 64,
  parameter int PORT_FIRST   = 1024,
  parameter int PORT_LIMIT   = 5000,
  parameter int ADDR_BITS    = 32
) (
  input logic     clk,
  input logic     rst_n,
  sdt_in_if.sink  in_ch,
  sdt_out_if.source out_ch
);
  import sdt_pkg::*;

  localparam int IW  = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
  localparam int PD  = PORT_LIMIT - PORT_FIRST;
  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_P1   = 4'd2;  // search pass down the chain
  localparam logic [3:0] S_P2   = 4'd3;  // write / evict pass
  localparam logic [3:0] S_CRD  = 4'd4;  // count read
  localparam logic [3:0] S_CWR  = 4'd5;  // count write back
  localparam logic [3:0] S_ARD  = 4'd6;  // allocate probe read
  localparam logic [3:0] S_AEV  = 4'd7;  // allocate probe check
  localparam logic [3:0] S_DONE = 4'd8;

  function automatic logic [15:0] next_port(input logic [15:0] p);
    logic [16:0] s;
    s = 17'(p) + 17'd1;
    return (s == 17'(PORT_LIMIT)) ? 16'(PORT_FIRST) : s[15:0];
  endfunction

  function automatic logic in_range(input logic [15:0] p);
    return (17'(p) >= 17'(PORT_FIRST)) && (17'(p) < 17'(PORT_LIMIT));
  endfunction

  function automatic logic [PAW-1:0] port_addr(input logic [15:0] p);
    logic [15:0] d;
    d = p - 16'(PORT_FIRST);
    return PAW'(d);
  endfunction

  logic [3:0]           state_r, state_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0] la_r, la_nxt, ra_r, ra_nxt;
  logic [15:0]          lp_r, lp_nxt, keep_r, keep_nxt;
  logic [16:0]          rp_r, rp_nxt;
  logic [5:0]           id_r, id_nxt;
  logic                 pass_r, pass_nxt, inject_r, inject_nxt;
  logic [PAW-1:0]       clr_r, clr_nxt;
  logic [15:0]          last_r, last_nxt, cur_r, cur_nxt;
  logic                 dn_en_r, dn_en_nxt, up_en_r, up_en_nxt, op_dn_r, op_dn_nxt;
  logic [15:0]          dn_p_r, dn_p_nxt, up_p_r, up_p_nxt;
  logic [PAW-1:0]       waddr_r, waddr_nxt;
  // pending result
  logic [2:0]           rs_st_r, rs_st_nxt;
  logic [5:0]           rs_fc_r, rs_fc_nxt;
  logic [1:0]           rs_lv_r, rs_lv_nxt;
  logic [15:0]          rs_pt_r, rs_pt_nxt;
  // output register
  logic                 ov_r, ov_nxt;
  logic [2:0]           o_st_r, o_st_nxt;
  logic [5:0]           o_fc_r, o_fc_nxt;
  logic [1:0]           o_lv_r, o_lv_nxt;
  logic [15:0]          o_pt_r, o_pt_nxt;

  // memory controls
  logic           m_we, m_re;
  logic [PAW-1:0] m_waddr, m_raddr;
  logic [6:0]     m_wdata, m_rdata;

  // cell chain
  sdt_carry_t    chain [CONN_ENTRIES+1];
  logic [IW-1:0] chid  [CONN_ENTRIES+1];
  sdt_carry_t    head;
  sdt_carry_t    tail;
  logic          id_bad;

  // wave enters the chain with only its live flag set
  always_comb begin
    head      = '0;
    head.live = inject_r;
  end

  assign chain[0] = head;
  assign chid[0]  = '0;

  for (genvar g = 0; g < CONN_ENTRIES; g++) begin : g_cell
    sdt_cell #(.IDX(g), .IW(IW), .ADDR_BITS(ADDR_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .q_pass(pass_r), .q_cmd(cmd_r), .q_la(la_r), .q_ra(ra_r), .q_lp(lp_r),
      .q_rp(rp_r), .q_id(id_r), .q_keep(keep_r),
      .c_in(chain[g]), .id_in(chid[g]), .c_out(chain[g+1]), .id_out(chid[g+1])
    );
  end

  assign tail = chain[CONN_ENTRIES];

  sdt_port_mem #(.DEPTH(PD), .AW(PAW)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(m_raddr), .rdata(m_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign id_bad      = (32'(in_ch.conn_id) >= 32'(CONN_ENTRIES));

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r; la_nxt = la_r; ra_nxt = ra_r; lp_nxt = lp_r; rp_nxt = rp_r;
    id_nxt = id_r; keep_nxt = keep_r; pass_nxt = pass_r; inject_nxt = 1'b0;
    clr_nxt = clr_r; last_nxt = last_r; cur_nxt = cur_r;
    dn_en_nxt = dn_en_r; up_en_nxt = up_en_r; op_dn_nxt = op_dn_r;
    dn_p_nxt = dn_p_r; up_p_nxt = up_p_r; waddr_nxt = waddr_r;
    rs_st_nxt = rs_st_r; rs_fc_nxt = rs_fc_r; rs_lv_nxt = rs_lv_r; rs_pt_nxt = rs_pt_r;
    ov_nxt = ov_r; o_st_nxt = o_st_r; o_fc_nxt = o_fc_r; o_lv_nxt = o_lv_r;
    o_pt_nxt = o_pt_r;
    m_we = 1'b0; m_waddr = waddr_r; m_wdata = '0; m_re = 1'b0; m_raddr = '0;

    // result beat leaves the output register
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        clr_nxt = clr_r + PAW'(1);
        if (32'(clr_r) == PD - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt  = in_ch.command;
          la_nxt   = in_ch.local_addr;
          ra_nxt   = in_ch.remote_addr;
          lp_nxt   = in_ch.local_port;
          rp_nxt   = in_ch.remote_port;
          id_nxt   = in_ch.conn_id;
          pass_nxt = 1'b0;
          dn_en_nxt = 1'b0;
          up_en_nxt = 1'b0;
          rs_st_nxt = ST_MISS; rs_fc_nxt = '0; rs_lv_nxt = '0; rs_pt_nxt = '0;
          case (in_ch.command) inside
            CMD_LOOKUP: begin
              inject_nxt = 1'b1;
              state_nxt  = S_P1;
            end
            CMD_INSERT, CMD_UPDATE, CMD_REMOVE: begin
              if (id_bad) begin
                rs_st_nxt = ST_ABSENT;
                state_nxt = S_DONE;
              end else begin
                inject_nxt = 1'b1;
                state_nxt  = S_P1;
              end
            end
            CMD_ALLOC: begin
              cur_nxt   = next_port(last_r);
              state_nxt = S_ARD;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_P1: begin
        if (tail.live) begin
          state_nxt = S_DONE;
          case (cmd_r)
            CMD_LOOKUP: begin
              if (tail.hit) begin
                rs_st_nxt = ST_OK;
                rs_fc_nxt = 6'(chid[CONN_ENTRIES]);
                rs_lv_nxt = tail.level;
              end
            end
            CMD_INSERT: begin
              // exact key anywhere in the table blocks the insert
              if (tail.hit && tail.level == 2'd0) begin
                rs_st_nxt = ST_IN_USE;
              end else begin
                dn_en_nxt = tail.own_valid;
                dn_p_nxt  = tail.own_lp;
                up_en_nxt = 1'b1;
                up_p_nxt  = lp_r;
                pass_nxt  = 1'b1;
                inject_nxt = 1'b1;
                state_nxt = S_P2;
              end
            end
            default: begin
              if (!tail.own_valid) begin
                rs_st_nxt = ST_ABSENT;
              end else begin
                keep_nxt   = tail.own_lp;
                dn_en_nxt  = (cmd_r == CMD_REMOVE);
                dn_p_nxt   = tail.own_lp;
                pass_nxt   = 1'b1;
                inject_nxt = 1'b1;
                state_nxt  = S_P2;
              end
            end
          endcase
        end
      end
      S_P2: begin
        if (tail.live) begin
          rs_st_nxt = ST_OK;
          if (cmd_r == CMD_UPDATE) begin
            dn_en_nxt = tail.ev;
            dn_p_nxt  = tail.ev_lp;
          end
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        // down count first, then up, each as read then write back
        if (dn_en_r) begin
          if (in_range(dn_p_r)) begin
            m_re = 1'b1; m_raddr = port_addr(dn_p_r);
            waddr_nxt = port_addr(dn_p_r);
            op_dn_nxt = 1'b1;
            state_nxt = S_CWR;
          end else begin
            dn_en_nxt = 1'b0;
          end
        end else if (up_en_r) begin
          if (in_range(up_p_r)) begin
            m_re = 1'b1; m_raddr = port_addr(up_p_r);
            waddr_nxt = port_addr(up_p_r);
            op_dn_nxt = 1'b0;
            state_nxt = S_CWR;
          end else begin
            up_en_nxt = 1'b0;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CWR: begin
        m_we = 1'b1;
        if (op_dn_r) begin
          m_wdata   = (m_rdata != '0) ? m_rdata - 7'd1 : m_rdata;
          dn_en_nxt = 1'b0;
        end else begin
          m_wdata   = (m_rdata < COUNT_MAX) ? m_rdata + 7'd1 : m_rdata;
          up_en_nxt = 1'b0;
        end
        state_nxt = S_CRD;
      end
      S_ARD: begin
        m_re = 1'b1; m_raddr = port_addr(cur_r);
        state_nxt = S_AEV;
      end
      S_AEV: begin
        if (m_rdata == '0) begin
          rs_st_nxt = ST_OK;
          rs_pt_nxt = cur_r;
          last_nxt  = cur_r;
          state_nxt = S_DONE;
        end else if (cur_r == last_r) begin
          rs_st_nxt = ST_EXHAUSTED;
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = next_port(cur_r);
          state_nxt = S_ARD;
        end
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          o_st_nxt = rs_st_r; o_fc_nxt = rs_fc_r; o_lv_nxt = rs_lv_r; o_pt_nxt = rs_pt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      inject_r <= 1'b0;
      pass_r   <= 1'b0;
      last_r   <= 16'(PORT_FIRST);
      dn_en_r  <= 1'b0;
      up_en_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      inject_r <= inject_nxt;
      pass_r   <= pass_nxt;
      last_r   <= last_nxt;
      dn_en_r  <= dn_en_nxt;
      up_en_r  <= up_en_nxt;
      ov_r     <= ov_nxt;
    end
    cmd_r <= cmd_nxt; la_r <= la_nxt; ra_r <= ra_nxt; lp_r <= lp_nxt; rp_r <= rp_nxt;
    id_r <= id_nxt; keep_r <= keep_nxt; cur_r <= cur_nxt; op_dn_r <= op_dn_nxt;
    dn_p_r <= dn_p_nxt; up_p_r <= up_p_nxt; waddr_r <= waddr_nxt;
    rs_st_r <= rs_st_nxt; rs_fc_r <= rs_fc_nxt; rs_lv_r <= rs_lv_nxt; rs_pt_r <= rs_pt_nxt;
    o_st_r <= o_st_nxt; o_fc_r <= o_fc_nxt; o_lv_r <= o_lv_nxt; o_pt_r <= o_pt_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = o_st_r;
  assign out_ch.found_conn  = o_fc_r;
  assign out_ch.match_level = o_lv_r;
  assign out_ch.port        = o_pt_r;
endmodule

### src/sdt_checker.sv
// port level checker for the table core, with its bind
`include "assert_macros.svh"

module sdt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [5:0]  found_conn,
  input logic [1:0]  match_level,
  input logic [15:0] port
);
  import sdt_pkg::*;

  `SDT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `SDT_ASSERT_MSG(a_status_range, clk, rst_n, out_valid |-> status <= ST_EXHAUSTED, "bad status")
  `SDT_ASSERT_MSG(a_miss_clean, clk, rst_n, out_valid && status != ST_OK |-> found_conn == 6'd0 && match_level == 2'd0, "stale lookup fields")
  `SDT_ASSERT_MSG(a_port_ok, clk, rst_n, out_valid && port != 16'd0 |-> status == ST_OK, "port without ok")
endmodule

bind socket_pair_demux_table_core sdt_checker u_sdt_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .found_conn(out_ch.found_conn),
  .match_level(out_ch.match_level), .port(out_ch.port)
);

### sim/socket_pair_demux_table_core_tb.sv
// testbench for the connection demux table: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module socket_pair_demux_table_core_tb;
  import sdt_pkg::*;

  localparam int CONN_ENTRIES = 64;
  localparam int PORT_FIRST   = 1024;
  localparam int PORT_LIMIT   = 5000;
  localparam int RAND_ITEMS   = 1500;
  localparam int IDLE_LIMIT   = 20000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] la;
    logic [31:0] ra;
    logic [15:0] lp;
    logic [16:0] rp;
    logic [5:0]  id;
  } seg_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  found;
    logic [1:0]  level;
    logic [15:0] port;
  } demux_res_t;

  typedef struct packed {
    logic       typed;
    demux_res_t res;
  } typed_res_t;

  typedef struct packed {
    seg_cmd_t   c;
    typed_res_t t;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sdt_in_if #(.ADDR_BITS(32)) in_ch();
  sdt_out_if                  out_ch();

  socket_pair_demux_table_core #(
    .CONN_ENTRIES(CONN_ENTRIES),
    .PORT_FIRST(PORT_FIRST),
    .PORT_LIMIT(PORT_LIMIT),
    .ADDR_BITS(32)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // shadow of the connection table
  logic        tbl_valid [CONN_ENTRIES];
  logic [31:0] tbl_la [CONN_ENTRIES];
  logic [31:0] tbl_ra [CONN_ENTRIES];
  logic [15:0] tbl_lp [CONN_ENTRIES];
  logic [16:0] tbl_rp [CONN_ENTRIES];
  logic [6:0]  use_cnt [65536];
  logic [15:0] alloc_last;

  demux_res_t expected_res_q[$];
  typed_res_t typed_q[$];
  int         mismatches = 0;
  logic       long_hold_req = 1'b0;

  function automatic logic eph(input logic [15:0] p);
    return p >= PORT_FIRST && p < PORT_LIMIT;
  endfunction

  function automatic int find_conn(input logic [31:0] la, input logic [31:0] ra,
                                   input logic [15:0] lp, input logic [16:0] rp);
    for (int i = 0; i < CONN_ENTRIES; i++)
      if (tbl_valid[i] && tbl_la[i] == la && tbl_ra[i] == ra && tbl_lp[i] == lp &&
          tbl_rp[i] == rp)
        return i;
    return -1;
  endfunction

  task automatic port_up(input logic [15:0] p);
    if (eph(p) && use_cnt[p] != COUNT_MAX) use_cnt[p] = use_cnt[p] + 7'd1;
  endtask

  task automatic port_down(input logic [15:0] p);
    if (eph(p) && use_cnt[p] != 7'd0) use_cnt[p] = use_cnt[p] - 7'd1;
  endtask

  task automatic predict_demux(input seg_cmd_t c, output demux_res_t r);
    int          hit;
    logic [15:0] keep, cur, start;
    int          guard;
    r = '{status: ST_MISS, found: '0, level: '0, port: '0};
    case (c.cmd)
      CMD_LOOKUP: begin
        // exact, local wildcard, remote wildcard, both wildcards
        for (int k = 0; k < 4; k++) begin
          hit = find_conn(k[0] ? 32'd0 : c.la, k[1] ? 32'd0 : c.ra, c.lp,
                          k[1] ? RPORT_ANY : c.rp);
          if (hit >= 0) begin
            r.status = ST_OK;
            r.found  = hit[5:0];
            r.level  = k[1:0];
            break;
          end
        end
      end
      CMD_INSERT: begin
        if (find_conn(c.la, c.ra, c.lp, c.rp) >= 0) begin
          r.status = ST_IN_USE;
        end else begin
          if (tbl_valid[c.id]) port_down(tbl_lp[c.id]);
          tbl_valid[c.id] = 1'b1;
          tbl_la[c.id] = c.la;
          tbl_ra[c.id] = c.ra;
          tbl_lp[c.id] = c.lp;
          tbl_rp[c.id] = c.rp;
          port_up(c.lp);
          r.status = ST_OK;
        end
      end
      CMD_UPDATE: begin
        if (!tbl_valid[c.id]) begin
          r.status = ST_ABSENT;
        end else begin
          // local port stays; evict any other holder of the new key
          keep = tbl_lp[c.id];
          for (int i = 0; i < CONN_ENTRIES; i++)
            if (i != c.id && tbl_valid[i] && tbl_la[i] == c.la && tbl_ra[i] == c.ra &&
                tbl_lp[i] == keep && tbl_rp[i] == c.rp) begin
              tbl_valid[i] = 1'b0;
              port_down(tbl_lp[i]);
            end
          tbl_la[c.id] = c.la;
          tbl_ra[c.id] = c.ra;
          tbl_rp[c.id] = c.rp;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (!tbl_valid[c.id]) begin
          r.status = ST_ABSENT;
        end else begin
          tbl_valid[c.id] = 1'b0;
          port_down(tbl_lp[c.id]);
          r.status = ST_OK;
        end
      end
      CMD_ALLOC: begin
        // round-robin scan from the port after the last one handed out
        start = alloc_last;
        cur = start + 16'd1;
        guard = 0;
        if (cur == PORT_LIMIT) cur = PORT_FIRST;
        r.status = ST_OK;
        while (use_cnt[cur] != 7'd0) begin
          if (cur == start || guard > 65536) begin
            r.status = ST_EXHAUSTED;
            break;
          end
          cur = cur + 16'd1;
          if (cur == PORT_LIMIT) cur = PORT_FIRST;
          guard++;
        end
        alloc_last = cur;
        if (r.status == ST_OK) r.port = cur;
      end
      default: ;
    endcase
  endtask

  // scoreboard: predict on each accepted command beat, check each result beat
  always @(posedge clk) begin
    demux_res_t got, want;
    seg_cmd_t   c;
    typed_res_t t;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{status: out_ch.status, found: out_ch.found_conn,
              level: out_ch.match_level, port: out_ch.port};
      if (expected_res_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = expected_res_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = '{cmd: in_ch.command, la: in_ch.local_addr, ra: in_ch.remote_addr,
            lp: in_ch.local_port, rp: in_ch.remote_port, id: in_ch.conn_id};
      predict_demux(c, want);
      t = typed_q.pop_front();
      // rows with a hand-written answer override the prediction
      if (t.typed) want = t.res;
      expected_res_q.push_back(want);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    int idle;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall per beat, one long hold on request
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ch.ready = 1'b0;
      n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 5);
      if (long_hold_req) begin
        n = 400;
        long_hold_req = 1'b0;
      end
      repeat (n) @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_cmd(input seg_cmd_t c, input typed_res_t t, input int gap);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command     = c.cmd;
    in_ch.local_addr  = c.la;
    in_ch.remote_addr = c.ra;
    in_ch.local_port  = c.lp;
    in_ch.remote_port = c.rp;
    in_ch.conn_id     = c.id;
    in_ch.valid       = 1'b1;
    typed_q.push_back(t);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (expected_res_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    logic [31:0] pool [4] = '{32'h0a000001, 32'h0a000002, 32'hc0a80001, 32'hc0a80002};
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffffffff;
      9: return $urandom;
      default: return pool[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic logic [15:0] pick_lport();
    logic [15:0] pool [8] = '{16'd80, 16'd81, 16'd1024, 16'd1025, 16'd1026, 16'd4999,
                              16'd5000, 16'd65535};
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
    return pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [16:0] pick_rport();
    case ($urandom_range(0, 5)) inside
      0, 1: return RPORT_ANY;
      2: return 17'd7;
      3: return 17'd9;
      4: return 17'd65535;
      default: return 17'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic seg_cmd_t rand_cmd();
    seg_cmd_t c;
    int       w, j;
    w = $urandom_range(0, 99);
    c.cmd = w < 35 ? CMD_LOOKUP : w < 65 ? CMD_INSERT : w < 75 ? CMD_UPDATE :
            w < 90 ? CMD_REMOVE : CMD_ALLOC;
    c.la = pick_addr();
    c.ra = pick_addr();
    c.lp = pick_lport();
    c.rp = pick_rport();
    c.id = $urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63)) :
                                       6'($urandom_range(0, 15));
    // half the lookups, when the picked entry is live, aim at a stored key, filling in its wildcards
    j = $urandom_range(0, 15);
    if (c.cmd == CMD_LOOKUP && $urandom_range(0, 1) && tbl_valid[j]) begin
      c.lp = tbl_lp[j];
      c.la = (tbl_la[j] == 0) ? $urandom : tbl_la[j];
      c.ra = (tbl_ra[j] == 0) ? $urandom : tbl_ra[j];
      c.rp = (tbl_rp[j] == RPORT_ANY) ? 17'($urandom_range(0, 65535)) : tbl_rp[j];
    end
    return c;
  endfunction

  function automatic dir_row_t row(input logic [2:0] cmd, input logic [31:0] la,
                                   input logic [31:0] ra, input logic [15:0] lp,
                                   input logic [16:0] rp, input logic [5:0] id,
                                   input logic typed, input logic [2:0] st,
                                   input logic [5:0] fc, input logic [15:0] port);
    return '{c: '{cmd, la, ra, lp, rp, id},
             t: '{typed, '{status: st, found: fc, level: 2'd0, port: port}}};
  endfunction

  localparam logic [31:0] A = 32'h0a000001, B = 32'h0a000002, C = 32'hc0a80001;

  initial begin
    dir_row_t dir_tab[$];
    seg_cmd_t c;
    for (int i = 0; i < CONN_ENTRIES; i++) tbl_valid[i] = 1'b0;
    for (int p = 0; p < 65536; p++) use_cnt[p] = 7'd0;
    alloc_last = PORT_FIRST;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOOKUP;
    in_ch.local_addr = '0;
    in_ch.remote_addr = '0;
    in_ch.local_port = '0;
    in_ch.remote_port = '0;
    in_ch.conn_id = '0;

    // empty table misses, first allocation, duplicates, every wildcard level,
    // absent ids, eviction on update, re-insert on a live id, all-ones extremes
    dir_tab = '{
      row(CMD_LOOKUP, A, B, 16'd80, 17'd7, 6'd0, 1, ST_MISS, 0, 0),
      row(CMD_ALLOC, 0, 0, 0, 0, 0, 1, ST_OK, 0, 16'd1025),
      row(CMD_INSERT, A, B, 16'd1026, 17'd7, 6'd0, 1, ST_OK, 0, 0),
      row(CMD_INSERT, A, B, 16'd1026, 17'd7, 6'd1, 1, ST_IN_USE, 0, 0),
      row(CMD_LOOKUP, A, B, 16'd1026, 17'd7, 6'd0, 1, ST_OK, 6'd0, 0),
      row(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_INSERT, 0, 0, 16'd80, RPORT_ANY, 6'd2, 1, ST_OK, 0, 0),
      row(CMD_LOOKUP, C, B, 16'd80, 17'd1234, 0, 0, 0, 0, 0),
      row(CMD_INSERT, C, 0, 16'd80, RPORT_ANY, 6'd3, 1, ST_OK, 0, 0),
      row(CMD_LOOKUP, C, B, 16'd80, 17'd5, 0, 0, 0, 0, 0),
      row(CMD_INSERT, 0, B, 16'd81, 17'd9, 6'd4, 1, ST_OK, 0, 0),
      row(CMD_LOOKUP, C, B, 16'd81, 17'd9, 0, 0, 0, 0, 0),
      row(CMD_UPDATE, A, B, 16'd81, 17'd9, 6'd5, 1, ST_ABSENT, 0, 0),
      row(CMD_REMOVE, 0, 0, 0, 0, 6'd5, 1, ST_ABSENT, 0, 0),
      row(CMD_INSERT, C, C, 16'd1026, 17'd1, 6'd6, 1, ST_OK, 0, 0),
      row(CMD_UPDATE, C, C, 16'd4999, 17'd1, 6'd0, 0, 0, 0, 0),
      row(CMD_LOOKUP, C, C, 16'd1026, 17'd1, 0, 0, 0, 0, 0),
      row(CMD_INSERT, B, A, 16'd4999, 17'd3, 6'd2, 0, 0, 0, 0),
      row(CMD_INSERT, '1, '1, 16'hffff, 17'd65535, 6'd63, 1, ST_OK, 0, 0),
      row(CMD_LOOKUP, '1, '1, 16'hffff, 17'd65535, 0, 1, ST_OK, 6'd63, 0),
      row(CMD_REMOVE, 0, 0, 0, 0, 6'd63, 1, ST_OK, 0, 0),
      row(CMD_REMOVE, 0, 0, 0, 0, 6'd0, 0, 0, 0, 0),
      row(CMD_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0),
      row(CMD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0, 0)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].t, $urandom_range(0, 2));
    drain_results();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // a long receiver hold while commands keep coming, then a full drain
      if (n == 400) long_hold_req = 1'b1;
      if (n == 800) drain_results();
      c = rand_cmd();
      send_cmd(c, '0, (n >= 1000 && n < 1100) ? 0 : $urandom_range(0, 5));
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_res_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/sdt_pkg.sv
src/sdt_in_if.sv
src/sdt_cell.sv
src/sdt_port_mem.sv
src/socket_pair_demux_table_core.sv
src/sdt_checker.sv
sim/socket_pair_demux_table_core_tb.sv
